// ===== src/pds_pkg.sv =====
// pds_pkg: shared types and constants for the PLL divider search block.
// Used by pds_div and pll_divider_search; depends on nothing.
package pds_pkg;

	localparam int SRC_W  = 20;
	localparam int VCO_W  = 19;
	localparam int N_W    = 8;
	localparam int M_W    = 5;
	localparam int R_W    = 4;
	localparam int FRAC_W = 8;
	localparam int MUL_AW = 8;
	localparam int MUL_BW = 20;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic [SRC_W-1:0]  TARGET_MAX = SRC_W'(170000);
	localparam logic [VCO_W-1:0]  VCO_MIN    = VCO_W'(96000);
	localparam logic [VCO_W-1:0]  DBL_R4_MAX = VCO_W'(86000);   // 344000 / 4
	localparam logic [VCO_W-1:0]  DBL_R3_MAX = VCO_W'(114666);  // 344000 / 3
	localparam logic [VCO_W-1:0]  DBL_R2_MAX = VCO_W'(172000);  // 344000 / 2
	localparam logic [FRAC_W-1:0] N_MAX      = FRAC_W'(127);
	localparam logic [FRAC_W-1:0] M_MAX      = FRAC_W'(16);

	typedef struct packed {
		logic [SRC_W-1:0] source_khz;
		logic [SRC_W-1:0] wanted_khz;
	} req_t;

	typedef struct packed {
		logic           found;
		logic [N_W-1:0] mult_n;
		logic [M_W-1:0] div_m;
		logic [R_W-1:0] div_r;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL_S,
		ST_MUL_T,
		ST_CMP,
		ST_DEC1,
		ST_DEC2,
		ST_DEC3
	} state_t;

endpackage

// ===== src/pll_divider_search.sv =====
// pll_divider_search: top level of the PLL divider search (N, M, R settings).
// Depends on pds_pkg and pds_div.
//
//  port     dir  width/type      meaning
//  start    in   1               request strobe, taken when busy is low
//  busy     out  1               high from accept until the result strobe
//  request  in   pds_pkg::req_t  source_khz, wanted_khz
//  done     out  1               result strobe, one cycle
//  result   out  pds_pkg::rsp_t  found, mult_n, div_m, div_r
//
// Sequence: an early failure ends in the prep state; otherwise prep, then the
// divider, then per search step that compares the states MUL_S, MUL_T and CMP,
// until the step count runs out or the bound check leads to the bracket pick
// in DEC1 to DEC3. The result strobe follows in the cycle after the last state.
// The 8x20 multiplier is shared, used once per cycle, and the divider yields
// one quotient bit per cycle.
// Reset clears the sequencer and the strobe; results are not held off, the
// receiver takes done/result in the cycle they appear. busy drops in that
// same cycle, so the next request may be taken there.
module pll_divider_search #(
	parameter int SEARCH_STEPS = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pds_pkg::req_t  request,
	output logic           done,
	output pds_pkg::rsp_t  result
);

	localparam int STEP_W = $clog2(SEARCH_STEPS + 1);
	localparam int FW = pds_pkg::FRAC_W;

	pds_pkg::state_t state_q, state_nxt;

	logic [pds_pkg::SRC_W-1:0]  src_q;
	logic [pds_pkg::SRC_W-1:0]  want_q;
	logic [pds_pkg::VCO_W-1:0]  vco_q;
	logic [pds_pkg::R_W-1:0]    rout_q;
	logic [FW-1:0]              lo_n_q, lo_d_q, hi_n_q, hi_d_q;
	logic [STEP_W-1:0]          step_q;
	logic [pds_pkg::MUL_PW-1:0] acc_q;
	logic [pds_pkg::MUL_PW-1:0] t_q;
	logic                       done_q;
	pds_pkg::rsp_t              result_q;

	// prep: R choice and VCO from the wanted frequency
	logic [pds_pkg::VCO_W-1:0]  dbl;
	logic [pds_pkg::VCO_W+1:0]  vco_wide;
	logic [pds_pkg::VCO_W-1:0]  vco_c;
	logic [pds_pkg::R_W-1:0]    rout_c;
	logic                       fail_c;

	always_comb begin
		dbl = {want_q[pds_pkg::VCO_W-2:0], 1'b0};
		if (dbl <= pds_pkg::DBL_R4_MAX) begin
			vco_wide = {dbl, 2'b00};
			rout_c   = pds_pkg::R_W'(8);
		end else if (dbl <= pds_pkg::DBL_R3_MAX) begin
			vco_wide = {2'b00, dbl} + {1'b0, dbl, 1'b0};
			rout_c   = pds_pkg::R_W'(6);
		end else if (dbl <= pds_pkg::DBL_R2_MAX) begin
			vco_wide = {1'b0, dbl, 1'b0};
			rout_c   = pds_pkg::R_W'(4);
		end else begin
			vco_wide = {2'b00, dbl};
			rout_c   = pds_pkg::R_W'(2);
		end
		vco_c  = vco_wide[pds_pkg::VCO_W-1:0];
		fail_c = (want_q > pds_pkg::TARGET_MAX) || (want_q == '0) || (src_q == '0)
			|| (vco_c < pds_pkg::VCO_MIN);
	end

	// initial quotient
	logic          div_start;
	logic          div_done;
	logic [FW-1:0] div_quo;

	pds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (vco_c),
		.divisor  (src_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// mediant, 8-bit wrap
	logic [FW-1:0] mid_n, mid_d;
	assign mid_n = lo_n_q + hi_n_q;
	assign mid_d = lo_d_q + hi_d_q;

	// shared multiplier, operands picked by the sequencer
	logic [pds_pkg::MUL_AW-1:0] mul_a;
	logic [pds_pkg::MUL_BW-1:0] mul_b;
	logic [pds_pkg::MUL_PW-1:0] mul_p;

	always_comb begin
		case (state_q)
			pds_pkg::ST_MUL_S: begin
				mul_a = mid_n;
				mul_b = src_q;
			end
			pds_pkg::ST_MUL_T: begin
				mul_a = mid_d;
				mul_b = pds_pkg::MUL_BW'(vco_q);
			end
			pds_pkg::ST_DEC1: begin
				mul_a = hi_n_q;
				mul_b = pds_pkg::MUL_BW'(lo_d_q);
			end
			pds_pkg::ST_DEC2: begin
				mul_a = lo_n_q;
				mul_b = pds_pkg::MUL_BW'(hi_d_q);
			end
			pds_pkg::ST_DEC3: begin
				mul_a = lo_d_q;
				mul_b = pds_pkg::MUL_BW'(hi_d_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = pds_pkg::MUL_PW'(mul_a) * pds_pkg::MUL_PW'(mul_b);

	// sequencer
	logic          fin;
	logic          fin_ok;
	logic [FW-1:0] fin_n;
	logic [FW-1:0] fin_d;
	logic          pick_hi;

	// VCO is nonzero here, so it drops out of the midpoint test
	assign pick_hi = ({mul_p[pds_pkg::MUL_PW-2:0], 1'b0} >= acc_q);

	always_comb begin
		state_nxt = state_q;
		div_start = 1'b0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_n     = '0;
		fin_d     = '0;
		case (state_q)
			pds_pkg::ST_IDLE: begin
				if (start)
					state_nxt = pds_pkg::ST_PREP;
			end
			pds_pkg::ST_PREP: begin
				if (fail_c) begin
					fin       = 1'b1;
					state_nxt = pds_pkg::ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_nxt = pds_pkg::ST_DIV;
				end
			end
			pds_pkg::ST_DIV: begin
				if (div_done)
					state_nxt = pds_pkg::ST_MUL_S;
			end
			pds_pkg::ST_MUL_S: begin
				if (step_q == STEP_W'(SEARCH_STEPS)) begin
					fin       = 1'b1;
					state_nxt = pds_pkg::ST_IDLE;
				end else if ((mid_n > pds_pkg::N_MAX) || (mid_d > pds_pkg::M_MAX)) begin
					state_nxt = pds_pkg::ST_DEC1;
				end else begin
					state_nxt = pds_pkg::ST_MUL_T;
				end
			end
			pds_pkg::ST_MUL_T: begin
				state_nxt = pds_pkg::ST_CMP;
			end
			pds_pkg::ST_CMP: begin
				if (acc_q == t_q) begin
					fin       = 1'b1;
					fin_ok    = 1'b1;
					fin_n     = mid_n;
					fin_d     = mid_d;
					state_nxt = pds_pkg::ST_IDLE;
				end else begin
					state_nxt = pds_pkg::ST_MUL_S;
				end
			end
			pds_pkg::ST_DEC1: begin
				state_nxt = pds_pkg::ST_DEC2;
			end
			pds_pkg::ST_DEC2: begin
				state_nxt = pds_pkg::ST_DEC3;
			end
			pds_pkg::ST_DEC3: begin
				fin       = 1'b1;
				fin_ok    = 1'b1;
				fin_n     = pick_hi ? hi_n_q : lo_n_q;
				fin_d     = pick_hi ? hi_d_q : lo_d_q;
				state_nxt = pds_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pds_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= fin;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == pds_pkg::ST_IDLE && start) begin
			src_q  <= request.source_khz;
			want_q <= request.wanted_khz;
		end
		if (state_q == pds_pkg::ST_PREP) begin
			vco_q  <= vco_c;
			rout_q <= rout_c;
		end
		if (state_q == pds_pkg::ST_DIV && div_done) begin
			lo_n_q <= div_quo;
			hi_n_q <= div_quo + 1'b1;
			lo_d_q <= FW'(1);
			hi_d_q <= FW'(1);
			step_q <= '0;
		end
		case (state_q)
			pds_pkg::ST_MUL_S: acc_q <= mul_p;
			pds_pkg::ST_MUL_T: t_q   <= mul_p;
			pds_pkg::ST_DEC1:  acc_q <= mul_p;
			pds_pkg::ST_DEC2:  acc_q <= acc_q + mul_p;
			pds_pkg::ST_CMP: begin
				step_q <= step_q + 1'b1;
				if (acc_q > t_q) begin
					hi_n_q <= mid_n;
					hi_d_q <= mid_d;
				end else begin
					lo_n_q <= mid_n;
					lo_d_q <= mid_d;
				end
			end
			default: ;
		endcase
		if (fin) begin
			result_q.found  <= fin_ok;
			result_q.mult_n <= fin_ok ? fin_n : '0;
			result_q.div_m  <= fin_ok ? fin_d[pds_pkg::M_W-1:0] : '0;
			result_q.div_r  <= fin_ok ? rout_q : '0;
		end
	end

	assign busy   = (state_q != pds_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/pds_div.sv =====
// pds_div: restoring divider, one quotient bit per cycle, VCO / source.
// Returns the low quotient byte. Depends on pds_pkg.
module pds_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pds_pkg::VCO_W-1:0]   dividend,
	input  logic [pds_pkg::SRC_W-1:0]   divisor,
	output logic                        done,
	output logic [pds_pkg::FRAC_W-1:0]  quotient
);

	localparam int STEPS = pds_pkg::VCO_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                       run_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [pds_pkg::SRC_W-1:0]  rem_q;
	logic [pds_pkg::VCO_W-1:0]  quo_q;
	logic [pds_pkg::SRC_W-1:0]  dsr_q;
	logic [pds_pkg::SRC_W:0]    shifted;
	logic [pds_pkg::SRC_W:0]    diff;
	logic                       fits;

	assign shifted = {rem_q, quo_q[pds_pkg::VCO_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			// remainder stays below divisor, so the low bits hold it
			rem_q <= fits ? diff[pds_pkg::SRC_W-1:0] : shifted[pds_pkg::SRC_W-1:0];
			quo_q <= {quo_q[pds_pkg::VCO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[pds_pkg::FRAC_W-1:0];

endmodule
